// ===== design/pli_pkg.sv =====
// Shared types, codes and constants of the piecewise linear interpolator.
package pli_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int VALUE_BITS_DEF  = 32;

    // Fixed field widths of the stream channels.
    localparam int IDX_W      = 6;
    localparam int FIELD_W    = 32;
    localparam int CNT_CFG_W  = 7;
    localparam int REGION_W   = 2;
    localparam int S_TDATA_W  = 72;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 4;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd0;
    localparam logic [REGION_W-1:0] REGION_INSIDE = 2'd1;
    localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

    // Table read address selection.
    localparam logic [2:0] RD_ZERO  = 3'd0;
    localparam logic [2:0] RD_LAST  = 3'd1;
    localparam logic [2:0] RD_P     = 3'd2;
    localparam logic [2:0] RD_P1    = 3'd3;
    localparam logic [2:0] RD_BASE  = 3'd4;
    localparam logic [2:0] RD_OTHER = 3'd5;

    typedef struct packed {
        logic                load_wr;
        logic                latch_x;
        logic                cap_first;
        logic [2:0]          rd_sel;
        logic                set_region;
        logic [REGION_W-1:0] region;
        logic                p_init;
        logic                p_inc;
        logic                p_dec;
        logic                prep;
        logic                mul_step;
        logic                div_init;
        logic                div_step;
        logic                out_load;
    } pli_cmd_t;

    typedef struct packed {
        logic x_le_first;
        logic x_lt_rd;
        logic x_gt_rd;
        logic p_lt_top;
        logic p_gt0;
        logic step_at_w;
        logic step_at_wm1;
        logic out_free;
    } pli_status_t;

endpackage

// ===== design/piecewise_linear_interpolator_core.sv =====
// Top level of the piecewise linear interpolator: controller plus datapath.
//
// Channel   Direction  tdata (low bit up)                        tuser (low bit up)
// s_axis    in         entry_index[5:0] x_value[37:6]             command[0]
//                      y_value[69:38], zeros[71:70]
// m_axis    out        interpolated[31:0]                        region[1:0] saturated[2]
//                                                                 zero_span[3]
// cfg       in         cfg_wdata = entry_count, written when cfg_we is high
//
// A load transfer produces no result. A query below or above the table skips the
// segment search; inside, the kept search pointer is moved entry by entry to the
// segment that holds the query. Each query uses the one-bit-per-cycle multiplier
// and divider and the single table read port.
// Reset is synchronous and active low; the table contents are not cleared.
// A finished result waits in the output register while m_axis_tready is low.
module piecewise_linear_interpolator_core #(
    parameter int MAX_ENTRIES = pli_pkg::MAX_ENTRIES_DEF,
    parameter int VALUE_BITS  = pli_pkg::VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pli_pkg::CNT_CFG_W-1:0]   cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // entry_index[5:0], x_value[37:6], y_value[69:38], zero fill [71:70]
    input  logic [pli_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // command[0]
    input  logic [pli_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // interpolated[31:0]
    output logic [pli_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // region[1:0], saturated[2], zero_span[3]
    output logic [pli_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    pli_pkg::pli_cmd_t    cmd;
    pli_pkg::pli_status_t status;
    logic                 in_ready;

    assign s_axis_tready = in_ready;

    pli_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_command (s_axis_tuser[0]),
        .in_ready   (in_ready),
        .status     (status),
        .cmd        (cmd)
    );

    pli_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_idx    (s_axis_tdata[5:0]),
        .in_x      (s_axis_tdata[37:6]),
        .in_y      (s_axis_tdata[69:38]),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .m_user    (m_axis_tuser)
    );

    a_region_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser[1:0] != 2'd3))
        else $error("result region code out of range");

    a_zero_not_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[3]) |-> !m_axis_tuser[2])
        else $error("zero-width segment reported as saturated");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == pli_pkg::CMD_QUERY)
        |=> !s_axis_tready)
        else $error("input taken while a query is in progress");

    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == pli_pkg::CMD_LOAD)
        |=> s_axis_tready)
        else $error("load transfer stalled the input");

endmodule

// ===== design/pli_ctrl.sv =====
// Sequencer for table load, segment search, multiply and divide of one query.
module pli_ctrl #(
    parameter int VALUE_BITS = pli_pkg::VALUE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_command,
    output logic                 in_ready,
    input  pli_pkg::pli_status_t status,
    output pli_pkg::pli_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_RD_FIRST = 4'd1;
    localparam logic [3:0] ST_CLASSIFY = 4'd2;
    localparam logic [3:0] ST_UP       = 4'd3;
    localparam logic [3:0] ST_UP_CHK   = 4'd4;
    localparam logic [3:0] ST_DN       = 4'd5;
    localparam logic [3:0] ST_DN_CHK   = 4'd6;
    localparam logic [3:0] ST_SEG_A    = 4'd7;
    localparam logic [3:0] ST_SEG_B    = 4'd8;
    localparam logic [3:0] ST_SEG_C    = 4'd9;
    localparam logic [3:0] ST_MUL      = 4'd10;
    localparam logic [3:0] ST_DIV_INIT = 4'd11;
    localparam logic [3:0] ST_DIV      = 4'd12;
    localparam logic [3:0] ST_DONE     = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = pli_pkg::RD_ZERO;
        cmd.region = pli_pkg::REGION_INSIDE;
        case (state_reg)
            ST_IDLE: begin
                // Entry zero is read every idle cycle so that it is ready next.
                if (in_valid) begin
                    if (in_command == pli_pkg::CMD_LOAD) begin
                        cmd.load_wr = 1'b1;
                    end else begin
                        cmd.latch_x = 1'b1;
                        state_next  = ST_RD_FIRST;
                    end
                end
            end
            ST_RD_FIRST: begin
                cmd.cap_first = 1'b1;
                cmd.rd_sel    = pli_pkg::RD_LAST;
                state_next    = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                if (status.x_le_first) begin
                    cmd.set_region = 1'b1;
                    cmd.region     = pli_pkg::REGION_BELOW;
                    state_next     = ST_SEG_A;
                end else if (!status.x_lt_rd) begin
                    cmd.set_region = 1'b1;
                    cmd.region     = pli_pkg::REGION_ABOVE;
                    state_next     = ST_SEG_A;
                end else begin
                    cmd.p_init = 1'b1;
                    state_next = ST_UP;
                end
            end
            ST_UP: begin
                if (status.p_lt_top) begin
                    cmd.rd_sel = pli_pkg::RD_P1;
                    state_next = ST_UP_CHK;
                end else begin
                    state_next = ST_DN;
                end
            end
            ST_UP_CHK: begin
                if (status.x_gt_rd) begin
                    cmd.p_inc  = 1'b1;
                    state_next = ST_UP;
                end else begin
                    state_next = ST_DN;
                end
            end
            ST_DN: begin
                if (status.p_gt0) begin
                    cmd.rd_sel = pli_pkg::RD_P;
                    state_next = ST_DN_CHK;
                end else begin
                    cmd.set_region = 1'b1;
                    state_next     = ST_SEG_A;
                end
            end
            ST_DN_CHK: begin
                if (status.x_lt_rd) begin
                    cmd.p_dec  = 1'b1;
                    state_next = ST_DN;
                end else begin
                    cmd.set_region = 1'b1;
                    state_next     = ST_SEG_A;
                end
            end
            ST_SEG_A: begin
                cmd.rd_sel = pli_pkg::RD_BASE;
                state_next = ST_SEG_B;
            end
            ST_SEG_B: begin
                cmd.rd_sel = pli_pkg::RD_OTHER;
                state_next = ST_SEG_C;
            end
            ST_SEG_C: begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (status.step_at_w) begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.step_at_wm1) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/pli_datapath.sv =====
// Table memory, search pointer, serial multiplier, serial divider and result register.
module pli_datapath #(
    parameter int MAX_ENTRIES = pli_pkg::MAX_ENTRIES_DEF,
    parameter int VALUE_BITS  = pli_pkg::VALUE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pli_pkg::CNT_CFG_W-1:0]     cfg_wdata,
    input  logic [pli_pkg::IDX_W-1:0]         in_idx,
    input  logic [pli_pkg::FIELD_W-1:0]       in_x,
    input  logic [pli_pkg::FIELD_W-1:0]       in_y,
    input  pli_pkg::pli_cmd_t                 cmd,
    output pli_pkg::pli_status_t              status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pli_pkg::M_TDATA_W-1:0]     m_data,
    output logic [pli_pkg::M_TUSER_W-1:0]     m_user
);

    localparam int W   = VALUE_BITS;
    localparam int W1  = W + 1;
    localparam int W2  = W + 2;
    localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int IW  = (W < pli_pkg::FIELD_W) ? W : pli_pkg::FIELD_W;
    localparam int SW  = $clog2(W + 1);

    localparam logic signed [W+1:0] VMAX_EXT = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] VMIN_EXT = {3'b111, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] VMAX     = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN     = {1'b1, {(W-1){1'b0}}};

    // Table storage, no reset.
    logic signed [W-1:0] tab_x [MAX_ENTRIES];
    logic signed [W-1:0] tab_y [MAX_ENTRIES];
    logic signed [W-1:0] rd_x_reg;
    logic signed [W-1:0] rd_y_reg;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                wr_en;

    logic signed [IW-1:0] x_narrow;
    logic signed [IW-1:0] y_narrow;
    logic signed [W-1:0]  x_in;
    logic signed [W-1:0]  y_in;

    logic [CW-1:0] count_reg;
    logic [AW-1:0] n_m1;
    logic [AW-1:0] n_m2;

    logic signed [W-1:0] x_reg;
    logic signed [W-1:0] first_x_reg;
    logic [AW-1:0]       p_reg;
    logic [AW-1:0]       search_pos_reg;
    logic [AW-1:0]       base_addr_reg;
    logic [AW-1:0]       other_addr_reg;
    logic [pli_pkg::REGION_W-1:0] region_reg;
    logic signed [W-1:0] base_x_reg;
    logic signed [W-1:0] base_y_reg;
    logic signed [W-1:0] left_reg;

    logic signed [W:0] a_diff;
    logic signed [W:0] dy_diff;
    logic signed [W:0] dx_diff;
    logic              neg_reg;
    logic              zero_reg;
    logic [W:0]        d_reg;
    logic [W:0]        mc_reg;
    logic [W+1:0]      hi_reg;
    logic [W:0]        lo_reg;
    logic [W+1:0]      mul_sum;
    logic [SW-1:0]     step_reg;

    logic [W+1:0]      div_r0;
    logic              ovf_reg;
    logic [W:0]        rem_reg;
    logic [W-1:0]      q_reg;
    logic [W+1:0]      div_t;
    logic [W+1:0]      div_sub;
    logic              div_ge;

    logic signed [W+1:0] sum_ext;
    logic signed [W+1:0] by_ext;
    logic signed [W+1:0] q_ext;
    logic signed [W-1:0] res;
    logic                res_sat;

    logic                            m_valid_reg;
    logic [pli_pkg::M_TDATA_W-1:0]   m_data_reg;
    logic [pli_pkg::M_TUSER_W-1:0]   m_user_reg;

    assign x_narrow = in_x[IW-1:0];
    assign y_narrow = in_y[IW-1:0];
    assign x_in     = W'(x_narrow);
    assign y_in     = W'(y_narrow);

    assign n_m1 = AW'(count_reg - CW'(1));
    assign n_m2 = AW'(count_reg - CW'(2));

    // A load beyond the table depth is dropped.
    assign wr_en   = cmd.load_wr && ({26'd0, in_idx} < 32'(MAX_ENTRIES));
    assign wr_addr = AW'(in_idx);

    always_comb begin
        case (cmd.rd_sel)
            pli_pkg::RD_ZERO:  rd_addr = '0;
            pli_pkg::RD_LAST:  rd_addr = n_m1;
            pli_pkg::RD_P:     rd_addr = p_reg;
            pli_pkg::RD_P1:    rd_addr = AW'(p_reg + AW'(1));
            pli_pkg::RD_BASE:  rd_addr = base_addr_reg;
            pli_pkg::RD_OTHER: rd_addr = other_addr_reg;
            default:           rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tab_x[wr_addr] <= x_in;
            tab_y[wr_addr] <= y_in;
        end
        rd_x_reg <= tab_x[rd_addr];
        rd_y_reg <= tab_y[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CW'(2);
        end else if (cfg_we) begin
            if (cfg_wdata < 7'd2) begin
                count_reg <= CW'(2);
            end else if (32'(cfg_wdata) > 32'(MAX_ENTRIES)) begin
                count_reg <= CW'(MAX_ENTRIES);
            end else begin
                count_reg <= CW'(cfg_wdata);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_pos_reg <= '0;
        end else if (cmd.set_region && cmd.region == pli_pkg::REGION_INSIDE) begin
            search_pos_reg <= p_reg;
        end
    end

    // Search and segment selection.
    always_ff @(posedge aclk) begin
        if (cmd.latch_x) begin
            x_reg <= x_in;
        end
        if (cmd.cap_first) begin
            first_x_reg <= rd_x_reg;
        end
        if (cmd.p_init) begin
            p_reg <= (search_pos_reg > n_m2) ? n_m2 : search_pos_reg;
        end else if (cmd.p_inc) begin
            p_reg <= AW'(p_reg + AW'(1));
        end else if (cmd.p_dec) begin
            p_reg <= AW'(p_reg - AW'(1));
        end
        if (cmd.set_region) begin
            region_reg <= cmd.region;
            case (cmd.region)
                pli_pkg::REGION_BELOW: begin
                    base_addr_reg  <= '0;
                    other_addr_reg <= AW'(1);
                end
                pli_pkg::REGION_ABOVE: begin
                    base_addr_reg  <= n_m1;
                    other_addr_reg <= n_m2;
                end
                default: begin
                    base_addr_reg  <= p_reg;
                    other_addr_reg <= AW'(p_reg + AW'(1));
                end
            endcase
        end
        if (cmd.rd_sel == pli_pkg::RD_OTHER) begin
            base_x_reg <= rd_x_reg;
            base_y_reg <= rd_y_reg;
        end
    end

    assign status.x_le_first = (x_reg <= first_x_reg);
    assign status.x_lt_rd    = (x_reg < rd_x_reg);
    assign status.x_gt_rd    = (x_reg > rd_x_reg);
    assign status.p_lt_top   = (p_reg < n_m2);
    assign status.p_gt0      = (p_reg != '0);
    assign status.step_at_w   = (step_reg == SW'(W));
    assign status.step_at_wm1 = (step_reg == SW'(W - 1));
    assign status.out_free    = !m_valid_reg || m_ready;

    // The other end of the segment is still in the read register here.
    assign a_diff  = W1'(x_reg) - W1'(base_x_reg);
    assign dy_diff = W1'(rd_y_reg) - W1'(base_y_reg);
    assign dx_diff = W1'(rd_x_reg) - W1'(base_x_reg);

    assign mul_sum = hi_reg + (lo_reg[0] ? {1'b0, mc_reg} : '0);

    assign div_r0  = {hi_reg[W:0], lo_reg[W]};
    assign div_t   = {rem_reg, q_reg[W-1]};
    assign div_sub = div_t - {1'b0, d_reg};
    assign div_ge  = (div_t >= {1'b0, d_reg});

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            neg_reg  <= a_diff[W] ^ dy_diff[W] ^ dx_diff[W];
            zero_reg <= (dx_diff == '0);
            d_reg    <= dx_diff[W] ? W1'(-dx_diff) : W1'(dx_diff);
            mc_reg   <= a_diff[W] ? W1'(-a_diff) : W1'(a_diff);
            lo_reg   <= dy_diff[W] ? W1'(-dy_diff) : W1'(dy_diff);
            hi_reg   <= '0;
            left_reg <= (region_reg == pli_pkg::REGION_ABOVE) ? rd_y_reg : base_y_reg;
            step_reg <= '0;
        end else if (cmd.mul_step) begin
            {hi_reg, lo_reg} <= {1'b0, mul_sum, lo_reg[W:1]};
            step_reg <= SW'(step_reg + SW'(1));
        end else if (cmd.div_init) begin
            // A quotient of 2**W or more saturates whatever the base sample is.
            ovf_reg  <= (div_r0 >= {1'b0, d_reg});
            rem_reg  <= div_r0[W:0];
            q_reg    <= lo_reg[W-1:0];
            step_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= div_ge ? div_sub[W:0] : div_t[W:0];
            q_reg    <= {q_reg[W-2:0], div_ge};
            step_reg <= SW'(step_reg + SW'(1));
        end
    end

    assign by_ext  = W2'(base_y_reg);
    assign q_ext   = signed'({2'b00, q_reg});
    assign sum_ext = neg_reg ? (by_ext - q_ext) : (by_ext + q_ext);

    always_comb begin
        res_sat = 1'b0;
        if (zero_reg) begin
            res = left_reg;
        end else if (ovf_reg) begin
            res_sat = 1'b1;
            res     = neg_reg ? VMIN : VMAX;
        end else if (sum_ext > VMAX_EXT) begin
            res_sat = 1'b1;
            res     = VMAX;
        end else if (sum_ext < VMIN_EXT) begin
            res_sat = 1'b1;
            res     = VMIN;
        end else begin
            res = sum_ext[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= pli_pkg::M_TDATA_W'(res);
            m_user_reg <= {zero_reg, res_sat, region_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_user  = m_user_reg;

endmodule
